// ----- sv/cbd_pkg.sv -----
// ----------------------------------------------------------------------------
// cbd_pkg
// shared constants, types and helpers of the circular buffer deque
// ----------------------------------------------------------------------------
package cbd_pkg;

	localparam int DEPTH      = 8;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CAP_W      = 4;
	localparam int CNT_W      = 4;
	localparam int SUM_W      = CNT_W + 1;
	localparam int CAP_RESET  = 8;

	localparam int IN_W  = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_BITS = 2 + 2 * DATA_WIDTH + CNT_W + 2;
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_READ = 2'd2
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic read;
	} cmd_t;

	// saturate a capacity register value into 1..DEPTH
	function automatic cnt_t eff_cap(input logic [CAP_W-1:0] c);
		cnt_t r;
		if (c == '0) begin
			r = cnt_t'(1);
		end else if (int'(c) > DEPTH) begin
			r = cnt_t'(DEPTH);
		end else begin
			r = cnt_t'(c);
		end
		return r;
	endfunction

	// wrap a sum that stays below twice the capacity
	function automatic idx_t wrap_idx(input logic [SUM_W-1:0] v, input cnt_t cap);
		logic [SUM_W-1:0] r;
		if (v >= {1'b0, cap}) begin
			r = v - {1'b0, cap};
		end else begin
			r = v;
		end
		return r[IDX_W-1:0];
	endfunction

endpackage

// ----- sv/cbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbd_ctrl
// sequencer of the deque: accept, execute, read back and output handshake
// ----------------------------------------------------------------------------
module cbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output cbd_pkg::cmd_t cmd
);

	cbd_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic slot_free;
	logic accept;

	assign slot_free = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			cbd_pkg::S_IDLE: begin
				s_tready = 1'b1;
			end
			cbd_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			cbd_pkg::S_READ: begin
				s_tready = slot_free;
				cmd.read = slot_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
		cmd.load = s_tready && s_tvalid;
	end

	assign accept = s_tready && s_tvalid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cbd_pkg::S_IDLE: begin
				if (accept) state_d = cbd_pkg::S_EXEC;
			end
			cbd_pkg::S_EXEC: begin
				state_d = cbd_pkg::S_READ;
			end
			cbd_pkg::S_READ: begin
				if (accept) begin
					state_d = cbd_pkg::S_EXEC;
				end else if (slot_free) begin
					state_d = cbd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cbd_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbd_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.read) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/cbd_datapath.sv -----
// ----------------------------------------------------------------------------
// cbd_datapath
// ring store, head and count registers, capacity and result registers
// ----------------------------------------------------------------------------
module cbd_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cbd_pkg::CAP_W-1:0]    cfg_data,
	input  cbd_pkg::cmd_t                cmd,
	input  logic [1:0]                   in_op,
	input  cbd_pkg::data_t               in_value,
	output logic [1:0]                   status,
	output cbd_pkg::data_t               front_value,
	output cbd_pkg::data_t               rear_value,
	output cbd_pkg::cnt_t                entry_count,
	output logic                         is_full,
	output logic                         is_empty
);

	cbd_pkg::data_t mem [cbd_pkg::DEPTH];

	cbd_pkg::op_t     op_q;
	cbd_pkg::data_t   val_q;
	cbd_pkg::idx_t    head_q;
	cbd_pkg::cnt_t    count_q;
	cbd_pkg::cnt_t    cap_q;
	cbd_pkg::status_t status_q;

	logic [1:0]     o_status_q;
	cbd_pkg::data_t o_front_q;
	cbd_pkg::data_t o_rear_q;
	cbd_pkg::cnt_t  o_count_q;
	logic           o_full_q;
	logic           o_empty_q;

	cbd_pkg::idx_t    head_d;
	cbd_pkg::cnt_t    count_d;
	cbd_pkg::status_t status_d;
	cbd_pkg::idx_t    wr_pos;
	logic             wr_en;
	logic             full;
	logic             empty;
	cbd_pkg::cnt_t    count_m1;
	cbd_pkg::idx_t    rear_idx;

	assign full  = (count_q >= cap_q);
	assign empty = (count_q == '0);

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = cbd_pkg::ST_DONE;
		wr_pos   = cbd_pkg::wrap_idx({1'b0, cbd_pkg::cnt_t'(head_q)} + {1'b0, count_q},
			cap_q);
		wr_en    = 1'b0;
		unique case (op_q)
			cbd_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status_d = cbd_pkg::ST_FULL;
				end else begin
					head_d  = (head_q == '0) ? cbd_pkg::idx_t'(cap_q - 1'b1)
						: head_q - 1'b1;
					wr_pos  = head_d;
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			cbd_pkg::OP_PUSH_REAR: begin
				if (full) begin
					status_d = cbd_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			cbd_pkg::OP_POP_FRONT: begin
				if (empty) begin
					status_d = cbd_pkg::ST_EMPTY;
				end else begin
					head_d  = cbd_pkg::wrap_idx({1'b0, cbd_pkg::cnt_t'(head_q)} + 1'b1,
						cap_q);
					count_d = count_q - 1'b1;
				end
			end
			cbd_pkg::OP_POP_REAR: begin
				if (empty) begin
					status_d = cbd_pkg::ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				status_d = cbd_pkg::ST_DONE;
			end
		endcase
	end

	// read back addresses from the updated head and count
	assign count_m1 = empty ? '0 : count_q - 1'b1;
	assign rear_idx = cbd_pkg::wrap_idx({1'b0, cbd_pkg::cnt_t'(head_q)} + {1'b0, count_m1},
		cap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			cap_q   <= cbd_pkg::eff_cap(cbd_pkg::CAP_W'(cbd_pkg::CAP_RESET));
		end else if (cfg_we) begin
			head_q  <= '0;
			count_q <= '0;
			cap_q   <= cbd_pkg::eff_cap(cfg_data);
		end else if (cmd.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= cbd_pkg::op_t'(in_op);
			val_q <= in_value;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			if (wr_en) mem[wr_pos] <= val_q;
		end
		if (cmd.read) begin
			o_status_q <= status_q;
			o_front_q  <= mem[head_q];
			o_rear_q   <= mem[rear_idx];
			o_count_q  <= count_q;
			o_full_q   <= (count_q == cap_q);
			o_empty_q  <= empty;
		end
	end

	assign status      = o_status_q;
	assign front_value = o_empty_q ? '1 : o_front_q;
	assign rear_value  = o_empty_q ? '1 : o_rear_q;
	assign entry_count = o_count_q;
	assign is_full     = o_full_q;
	assign is_empty    = o_empty_q;

endmodule

// ----- sv/circular_buffer_deque_unit.sv -----
// ----------------------------------------------------------------------------
// circular_buffer_deque_unit
// double-ended queue in a ring of signed entries with a settable capacity
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         tvalid / tready    tuser: op, tdata: push_value
//  m_*       out        tvalid / tready    tdata: result of one operation
//  cfg_*     in         cfg_we             cfg_data: capacity_in_use
//
//  an item passes the execute state, which updates head and count and
//  writes the ring, then the read state, which loads front and rear from
//  the ring port into the output register. an item is taken in the read
//  state when the output register is free or being drained; a stalled
//  output holds the sequencer in the read state. reset empties the queue
//  and sets the capacity to the built depth; ring contents need no clearing.
// ----------------------------------------------------------------------------
module circular_buffer_deque_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cbd_pkg::CAP_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cbd_pkg::IN_W-1:0]      s_tdata,  // push_value
	input  logic [1:0]                    s_tuser,  // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status, front_value, rear_value, entry_count, is_full, is_empty
	output logic [cbd_pkg::OUT_W-1:0]     m_tdata
);

	cbd_pkg::cmd_t  cmd;
	logic [1:0]     status;
	cbd_pkg::data_t front_value;
	cbd_pkg::data_t rear_value;
	cbd_pkg::cnt_t  entry_count;
	logic           is_full;
	logic           is_empty;

	cbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	cbd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.in_op       (s_tuser),
		.in_value    (s_tdata[cbd_pkg::DATA_WIDTH-1:0]),
		.status      (status),
		.front_value (front_value),
		.rear_value  (rear_value),
		.entry_count (entry_count),
		.is_full     (is_full),
		.is_empty    (is_empty)
	);

	assign m_tdata = cbd_pkg::OUT_W'({is_empty, is_full, entry_count, rear_value,
		front_value, status});

endmodule
